/* hdl/bma_pkg.sv */
// ----------------------------------------------------------------------------
// bma_pkg
// Shared widths, register map, level codes and reset values for the battery
// monitor averager.
// ----------------------------------------------------------------------------
package bma_pkg;

  // sample and average width
  localparam int DATA_W = 16;
  localparam int LEVEL_W = 3;

  // default window depths
  localparam int BATTERY_TAPS_DEF = 8;
  localparam int AUX_TAPS_DEF = 8;

  // register map
  localparam int REG_COUNT = 5;
  localparam int REG_IDX_W = 3;
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;

  localparam logic [REG_IDX_W-1:0] REG_CRIT          = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_EMPTY         = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_QUARTER       = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_HALF          = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_THREE_QUARTER = 3'd4;

  // threshold reset values in millivolts
  localparam logic [DATA_W-1:0] CRIT_RST          = 16'd3000;
  localparam logic [DATA_W-1:0] EMPTY_RST         = 16'd3300;
  localparam logic [DATA_W-1:0] QUARTER_RST       = 16'd3500;
  localparam logic [DATA_W-1:0] HALF_RST          = 16'd3700;
  localparam logic [DATA_W-1:0] THREE_QUARTER_RST = 16'd3900;

  // battery level codes
  localparam logic [LEVEL_W-1:0] LEVEL_CRIT          = 3'd0;
  localparam logic [LEVEL_W-1:0] LEVEL_EMPTY         = 3'd1;
  localparam logic [LEVEL_W-1:0] LEVEL_QUARTER       = 3'd2;
  localparam logic [LEVEL_W-1:0] LEVEL_HALF          = 3'd3;
  localparam logic [LEVEL_W-1:0] LEVEL_THREE_QUARTER = 3'd4;
  localparam logic [LEVEL_W-1:0] LEVEL_FULL          = 3'd5;

endpackage

/* hdl/battery_monitor_averager.sv */
// ----------------------------------------------------------------------------
// battery_monitor_averager
// Boxcar averages of battery voltage, load current, USB voltage and USB
// current, with a six-step battery level from five programmable thresholds.
// ----------------------------------------------------------------------------
//
//   channel  | signals                                  | moves
//   ---------+------------------------------------------+----------------------
//   input    | in_valid/in_ready + sample fields        | one sample set
//   output   | out_valid/out_ready + average fields     | one averaged result
//   config   | psel/penable/pwrite/paddr/pwdata/prdata  | threshold registers
//
// One request is taken every cycle while in_ready is high; each result is
// registered through the window update, reciprocal multiply and level stages.
// The windows are rows of tap cells that shift on each accepted request.
// Reset clears the windows, sums and stage valids and loads the threshold reset values.
// A stalled output holds its result; the stages behind it keep filling
// bubbles and in_ready drops only once every stage is full.
//
module battery_monitor_averager #(
  parameter int BATTERY_TAPS = bma_pkg::BATTERY_TAPS_DEF,
  parameter int AUX_TAPS     = bma_pkg::AUX_TAPS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // input channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [bma_pkg::DATA_W-1:0]          battery_mv,
  input  logic                                battery_valid,
  input  logic [bma_pkg::DATA_W-1:0]          load_ma,
  input  logic [bma_pkg::DATA_W-1:0]          usb_mv,
  input  logic [bma_pkg::DATA_W-1:0]          usb_ma,
  // output channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [bma_pkg::DATA_W-1:0]          avg_battery_mv,
  output logic [bma_pkg::DATA_W-1:0]          avg_load_ma,
  output logic [bma_pkg::DATA_W-1:0]          avg_usb_mv,
  output logic [bma_pkg::DATA_W-1:0]          avg_usb_ma,
  output logic [bma_pkg::LEVEL_W-1:0]         battery_level,
  // configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [bma_pkg::PADDR_W-1:0]         paddr,
  input  logic [bma_pkg::PDATA_W-1:0]         pwdata,
  output logic [bma_pkg::PDATA_W-1:0]         prdata,
  output logic                                pready
);

  import bma_pkg::*;

  localparam int BSUM_W = DATA_W + $clog2(BATTERY_TAPS);
  localparam int ASUM_W = DATA_W + $clog2(AUX_TAPS);

  logic [DATA_W-1:0] crit_threshold_mv;
  logic [DATA_W-1:0] empty_threshold_mv;
  logic [DATA_W-1:0] quarter_threshold_mv;
  logic [DATA_W-1:0] half_threshold_mv;
  logic [DATA_W-1:0] three_quarter_threshold_mv;

  logic              cfg_write;
  logic [REG_IDX_W-1:0] reg_idx;

  logic              in_accept;
  logic              primed;
  logic              bat_fill;
  logic              bat_shift;
  logic              aux_fill;
  logic              aux_shift;

  logic [BSUM_W-1:0] bat_sum_next;
  logic [ASUM_W-1:0] load_sum_next;
  logic [ASUM_W-1:0] usbv_sum_next;
  logic [ASUM_W-1:0] usbi_sum_next;

  // pipeline stage valids and stage-ready chain
  logic              s1_valid;
  logic              s2_valid;
  logic              s3_valid;
  logic              s1_ready;
  logic              s2_ready;
  logic              s3_ready;

  logic [BSUM_W-1:0] s1_bat_sum;
  logic [ASUM_W-1:0] s1_load_sum;
  logic [ASUM_W-1:0] s1_usbv_sum;
  logic [ASUM_W-1:0] s1_usbi_sum;

  logic [DATA_W-1:0] bat_quot;
  logic [DATA_W-1:0] load_quot;
  logic [DATA_W-1:0] usbv_quot;
  logic [DATA_W-1:0] usbi_quot;

  logic [DATA_W-1:0] s2_bat_avg;
  logic [DATA_W-1:0] s2_load_avg;
  logic [DATA_W-1:0] s2_usbv_avg;
  logic [DATA_W-1:0] s2_usbi_avg;

  logic [DATA_W-1:0]  s3_bat_avg;
  logic [DATA_W-1:0]  s3_load_avg;
  logic [DATA_W-1:0]  s3_usbv_avg;
  logic [DATA_W-1:0]  s3_usbi_avg;
  logic [LEVEL_W-1:0] s3_level;
  logic [LEVEL_W-1:0] level_next;

  // threshold registers
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;
  assign reg_idx   = paddr[PADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      crit_threshold_mv          <= CRIT_RST;
      empty_threshold_mv         <= EMPTY_RST;
      quarter_threshold_mv       <= QUARTER_RST;
      half_threshold_mv          <= HALF_RST;
      three_quarter_threshold_mv <= THREE_QUARTER_RST;
    end else if (cfg_write) begin
      case (reg_idx)
        REG_CRIT:          crit_threshold_mv          <= pwdata[DATA_W-1:0];
        REG_EMPTY:         empty_threshold_mv         <= pwdata[DATA_W-1:0];
        REG_QUARTER:       quarter_threshold_mv       <= pwdata[DATA_W-1:0];
        REG_HALF:          half_threshold_mv          <= pwdata[DATA_W-1:0];
        REG_THREE_QUARTER: three_quarter_threshold_mv <= pwdata[DATA_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // register read
  always_comb begin
    case (reg_idx)
      REG_CRIT:          prdata = {{(PDATA_W-DATA_W){1'b0}}, crit_threshold_mv};
      REG_EMPTY:         prdata = {{(PDATA_W-DATA_W){1'b0}}, empty_threshold_mv};
      REG_QUARTER:       prdata = {{(PDATA_W-DATA_W){1'b0}}, quarter_threshold_mv};
      REG_HALF:          prdata = {{(PDATA_W-DATA_W){1'b0}}, half_threshold_mv};
      REG_THREE_QUARTER: prdata = {{(PDATA_W-DATA_W){1'b0}}, three_quarter_threshold_mv};
      default:           prdata = '0;
    endcase
  end

  // stage ready chain, bubbles collapse behind a stalled output
  assign s3_ready  = ~s3_valid | out_ready;
  assign s2_ready  = ~s2_valid | s3_ready;
  assign s1_ready  = ~s1_valid | s2_ready;
  assign in_ready  = s1_ready;
  assign in_accept = in_valid & in_ready;

  // first request primes the aux windows, and the battery window if battery_valid, with its own values
  assign bat_fill  = in_accept & ~primed & battery_valid;
  assign bat_shift = in_accept & primed & battery_valid;
  assign aux_fill  = in_accept & ~primed;
  assign aux_shift = in_accept & primed;

  always_ff @(posedge clk) begin
    if (rst) begin
      primed <= 1'b0;
    end else if (in_accept) begin
      primed <= 1'b1;
    end
  end

  // the four windows
  bma_window #(.TAPS(BATTERY_TAPS), .DATA_W(DATA_W), .SUM_W(BSUM_W)) u_bat_win (
    .clk      (clk),
    .rst      (rst),
    .shift_en (bat_shift),
    .fill_en  (bat_fill),
    .sample   (battery_mv),
    .sum_next (bat_sum_next)
  );

  bma_window #(.TAPS(AUX_TAPS), .DATA_W(DATA_W), .SUM_W(ASUM_W)) u_load_win (
    .clk      (clk),
    .rst      (rst),
    .shift_en (aux_shift),
    .fill_en  (aux_fill),
    .sample   (load_ma),
    .sum_next (load_sum_next)
  );

  bma_window #(.TAPS(AUX_TAPS), .DATA_W(DATA_W), .SUM_W(ASUM_W)) u_usbv_win (
    .clk      (clk),
    .rst      (rst),
    .shift_en (aux_shift),
    .fill_en  (aux_fill),
    .sample   (usb_mv),
    .sum_next (usbv_sum_next)
  );

  bma_window #(.TAPS(AUX_TAPS), .DATA_W(DATA_W), .SUM_W(ASUM_W)) u_usbi_win (
    .clk      (clk),
    .rst      (rst),
    .shift_en (aux_shift),
    .fill_en  (aux_fill),
    .sample   (usb_ma),
    .sum_next (usbi_sum_next)
  );

  // stage 1: sums after this request, battery sum zeroed for an invalid sample
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= in_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_bat_sum  <= battery_valid ? bat_sum_next : '0;
      s1_load_sum <= load_sum_next;
      s1_usbv_sum <= usbv_sum_next;
      s1_usbi_sum <= usbi_sum_next;
    end
  end

  // stage 2: divide by tap count
  bma_div_taps #(.TAPS(BATTERY_TAPS), .DATA_W(DATA_W), .SUM_W(BSUM_W)) u_bat_div (
    .sum  (s1_bat_sum),
    .quot (bat_quot)
  );

  bma_div_taps #(.TAPS(AUX_TAPS), .DATA_W(DATA_W), .SUM_W(ASUM_W)) u_load_div (
    .sum  (s1_load_sum),
    .quot (load_quot)
  );

  bma_div_taps #(.TAPS(AUX_TAPS), .DATA_W(DATA_W), .SUM_W(ASUM_W)) u_usbv_div (
    .sum  (s1_usbv_sum),
    .quot (usbv_quot)
  );

  bma_div_taps #(.TAPS(AUX_TAPS), .DATA_W(DATA_W), .SUM_W(ASUM_W)) u_usbi_div (
    .sum  (s1_usbi_sum),
    .quot (usbi_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) begin
      s2_bat_avg  <= bat_quot;
      s2_load_avg <= load_quot;
      s2_usbv_avg <= usbv_quot;
      s2_usbi_avg <= usbi_quot;
    end
  end

  // stage 3: battery level, thresholds tried in rising order
  always_comb begin
    if (s2_bat_avg <= crit_threshold_mv) begin
      level_next = LEVEL_CRIT;
    end else if (s2_bat_avg <= empty_threshold_mv) begin
      level_next = LEVEL_EMPTY;
    end else if (s2_bat_avg <= quarter_threshold_mv) begin
      level_next = LEVEL_QUARTER;
    end else if (s2_bat_avg <= half_threshold_mv) begin
      level_next = LEVEL_HALF;
    end else if (s2_bat_avg <= three_quarter_threshold_mv) begin
      level_next = LEVEL_THREE_QUARTER;
    end else begin
      level_next = LEVEL_FULL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (s3_ready) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ready && s2_valid) begin
      s3_bat_avg  <= s2_bat_avg;
      s3_load_avg <= s2_load_avg;
      s3_usbv_avg <= s2_usbv_avg;
      s3_usbi_avg <= s2_usbi_avg;
      s3_level    <= level_next;
    end
  end

  // output register
  assign out_valid      = s3_valid;
  assign avg_battery_mv = s3_bat_avg;
  assign avg_load_ma    = s3_load_avg;
  assign avg_usb_mv     = s3_usbv_avg;
  assign avg_usb_ma     = s3_usbi_avg;
  assign battery_level  = s3_level;

  // a zero battery average is always at or below every threshold
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && avg_battery_mv == '0) |-> battery_level == LEVEL_CRIT)
    else $error("zero battery average without critical level");

  // level never beyond full
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> battery_level <= LEVEL_FULL)
    else $error("battery level out of range");

  // windows stay primed until reset
  assert property (@(posedge clk) disable iff (rst) !$fell(primed))
    else $error("primed flag dropped without reset");

  // a window is never filled and shifted together
  assert property (@(posedge clk) disable iff (rst)
    !(aux_fill && aux_shift) && !(bat_fill && bat_shift))
    else $error("window fill and shift together");

  // a full pipeline stalled at the output takes no new request
  assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s2_valid && s3_valid && !out_ready) |-> !in_ready)
    else $error("request taken into a full pipeline");

endmodule

/* hdl/bma_tap_cell.sv */
// ----------------------------------------------------------------------------
// bma_tap_cell
// One tap of a boxcar window: holds one sample and takes its neighbour's
// sample on a shift, or the fill value when the window is primed.
// ----------------------------------------------------------------------------
module bma_tap_cell #(
  parameter int DATA_W = bma_pkg::DATA_W
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              shift_en,
  input  logic              fill_en,
  input  logic [DATA_W-1:0] fill_value,
  input  logic [DATA_W-1:0] prev_value,
  output logic [DATA_W-1:0] value
);

  logic [DATA_W-1:0] sample;

  // tap storage, cleared so an unprimed window reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      sample <= '0;
    end else if (fill_en) begin
      sample <= fill_value;
    end else if (shift_en) begin
      sample <= prev_value;
    end
  end

  assign value = sample;

endmodule

/* hdl/bma_window.sv */
// ----------------------------------------------------------------------------
// bma_window
// Boxcar window built as a row of tap cells with a running sum; the oldest
// sample drops off the far end of the row as a new one enters.
// ----------------------------------------------------------------------------
module bma_window #(
  parameter int TAPS   = bma_pkg::BATTERY_TAPS_DEF,
  parameter int DATA_W = bma_pkg::DATA_W,
  parameter int SUM_W  = DATA_W + $clog2(TAPS)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              shift_en,
  input  logic              fill_en,
  input  logic [DATA_W-1:0] sample,
  output logic [SUM_W-1:0]  sum_next
);

  logic [DATA_W-1:0] tap_q [TAPS];
  logic [SUM_W-1:0]  sum;
  logic [SUM_W:0]    push_sum;
  logic [SUM_W-1:0]  fill_sum;

  // chain of cells, first cell takes the new sample
  for (genvar i = 0; i < TAPS; i++) begin : g_tap
    if (i == 0) begin : g_head
      bma_tap_cell #(.DATA_W(DATA_W)) u_cell (
        .clk        (clk),
        .rst        (rst),
        .shift_en   (shift_en),
        .fill_en    (fill_en),
        .fill_value (sample),
        .prev_value (sample),
        .value      (tap_q[i])
      );
    end else begin : g_body
      bma_tap_cell #(.DATA_W(DATA_W)) u_cell (
        .clk        (clk),
        .rst        (rst),
        .shift_en   (shift_en),
        .fill_en    (fill_en),
        .fill_value (sample),
        .prev_value (tap_q[i-1]),
        .value      (tap_q[i])
      );
    end
  end

  // running sum update: drop the oldest tap, add the new sample
  assign push_sum = {1'b0, sum} - {{(SUM_W+1-DATA_W){1'b0}}, tap_q[TAPS-1]}
                  + {{(SUM_W+1-DATA_W){1'b0}}, sample};
  assign fill_sum = SUM_W'({{(SUM_W-DATA_W){1'b0}}, sample} * SUM_W'(TAPS));

  always_comb begin
    if (fill_en) begin
      sum_next = fill_sum;
    end else if (shift_en) begin
      sum_next = push_sum[SUM_W-1:0];
    end else begin
      sum_next = sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
    end else begin
      sum <= sum_next;
    end
  end

endmodule

/* hdl/bma_div_taps.sv */
// ----------------------------------------------------------------------------
// bma_div_taps
// Truncating division of a window sum by the tap count, done as a multiply
// by a rounded-up reciprocal and a shift; exact for every sum of SUM_W bits.
// ----------------------------------------------------------------------------
module bma_div_taps #(
  parameter int TAPS   = bma_pkg::AUX_TAPS_DEF,
  parameter int DATA_W = bma_pkg::DATA_W,
  parameter int SUM_W  = DATA_W + $clog2(TAPS)
) (
  input  logic [SUM_W-1:0]  sum,
  output logic [DATA_W-1:0] quot
);

  localparam int SHIFT = SUM_W + $clog2(TAPS);
  localparam int MULT_W = SUM_W + 1;
  localparam int PROD_W = SUM_W + MULT_W;
  localparam longint unsigned MULT_VAL =
    ((64'd1 << SHIFT) + 64'(TAPS) - 64'd1) / 64'(TAPS);
  localparam logic [MULT_W-1:0] MULT = MULT_W'(MULT_VAL);

  logic [PROD_W-1:0] prod;

  // reciprocal multiply, quotient sits above the shift point
  assign prod = {{MULT_W{1'b0}}, sum} * {{SUM_W{1'b0}}, MULT};
  assign quot = prod[SHIFT +: DATA_W];

endmodule
